### rtl/core/lics_pkg.sv
`default_nettype none
package lics_pkg;

    localparam int unsigned CAPACITY  = 32;
    localparam int unsigned SIZE_BITS = 48;
    localparam int unsigned ID_BITS   = 16;

    localparam int unsigned STATUS_W = 3;
    localparam int unsigned HCOUNT_W = 6;
    localparam int unsigned HSUM_W   = 53;
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned PADDR_W  = 4;
    localparam int unsigned PDATA_W  = 64;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOWER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DRAIN = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LOWERED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ENTRY    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic do_add;
        logic do_lower;
        logic drain_start;
        logic do_drop;
        logic put_result;
        logic put_entry;
    } t_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             add_drop;
        logic             cnt_zero;
        logic             drop_ok;
        logic             drain_last;
        logic             out_free;
    } t_sts;

endpackage
`default_nettype wire

### rtl/core/lics_ctrl.sv
`default_nettype none
module lics_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    input  lics_pkg::t_sts     i_sts,
    output lics_pkg::t_ctl     o_ctl,
    output logic               o_idle
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_DROP  = 3'd2;
    localparam logic [2:0] S_RES   = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_sts.cmd)
                    lics_pkg::CMD_ADD: begin
                        o_ctl.do_add = 1'b1;
                        n_state      = i_sts.add_drop ? S_DROP : S_RES;
                    end
                    lics_pkg::CMD_LOWER: begin
                        o_ctl.do_lower = 1'b1;
                        n_state        = S_DROP;
                    end
                    lics_pkg::CMD_DRAIN: begin
                        o_ctl.drain_start = 1'b1;
                        n_state           = i_sts.cnt_zero ? S_RES : S_DRAIN;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_DROP: begin
                if (i_sts.drop_ok) begin
                    o_ctl.do_drop = 1'b1;
                end else begin
                    n_state = S_RES;
                end
            end
            S_RES: begin
                if (i_sts.out_free) begin
                    o_ctl.put_result = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_DRAIN: begin
                if (i_sts.out_free) begin
                    o_ctl.put_entry = 1'b1;
                    if (i_sts.drain_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_idle = (r_state == S_IDLE);

endmodule
`default_nettype wire

### rtl/core/lics_dp.sv
`default_nettype none
module lics_dp #(
    parameter int unsigned CAPACITY  = lics_pkg::CAPACITY,
    parameter int unsigned SIZE_BITS = lics_pkg::SIZE_BITS,
    parameter int unsigned ID_BITS   = lics_pkg::ID_BITS
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  lics_pkg::t_ctl                     i_ctl,
    output lics_pkg::t_sts                     o_sts,
    input  wire [lics_pkg::CMD_W-1:0]          i_cmd,
    input  wire [ID_BITS-1:0]                  i_item_id,
    input  wire [SIZE_BITS-1:0]                i_item_size,
    input  wire [SIZE_BITS-1:0]                i_decrease_amount,
    input  wire                                i_cfg_we,
    input  wire [SIZE_BITS-1:0]                i_cfg_data,
    output logic [SIZE_BITS-1:0]               o_init_req,
    input  wire                                i_out_stall,
    output logic                               o_out_valid,
    output logic [lics_pkg::STATUS_W-1:0]      o_status,
    output logic [ID_BITS-1:0]                 o_entry_id,
    output logic [SIZE_BITS-1:0]               o_entry_size,
    output logic [lics_pkg::HCOUNT_W-1:0]      o_held_count,
    output logic [lics_pkg::HSUM_W-1:0]        o_held_sum,
    output logic [SIZE_BITS-1:0]               o_requirement_now,
    output logic                               o_last
);

    localparam int unsigned CW    = $clog2(CAPACITY + 1);
    localparam int unsigned SUMC  = SIZE_BITS + $clog2(CAPACITY) + 1;
    localparam int unsigned SUMW  = (SUMC > lics_pkg::HSUM_W) ? SUMC : lics_pkg::HSUM_W;
    localparam int unsigned KEY_W = SIZE_BITS + ID_BITS;

    logic [SIZE_BITS-1:0] r_size [CAPACITY];
    logic [ID_BITS-1:0]   r_id   [CAPACITY];
    logic [CW-1:0]        r_cnt;
    logic [CW-1:0]        r_k;
    logic [SUMW-1:0]      r_sum;
    logic [SIZE_BITS-1:0] r_req;
    logic [SIZE_BITS-1:0] r_init;

    logic [lics_pkg::CMD_W-1:0]    r_cmd;
    logic [ID_BITS-1:0]            r_nid;
    logic [SIZE_BITS-1:0]          r_nsize;
    logic [SIZE_BITS-1:0]          r_dec;
    logic [lics_pkg::STATUS_W-1:0] r_st;

    logic [CAPACITY-1:0] less;
    logic [CAPACITY-1:0] eq;
    logic                dup;
    logic                full;
    logic                sum_lt;
    logic                small_ign;
    logic [lics_pkg::STATUS_W-1:0] add_st;
    logic                add_ins;
    logic                drop_ok;
    logic                drain_last;
    logic                out_free;
    logic [SUMW-1:0]     sum_less0;

    // Every cell compares its key against the new item at once; the held
    // entries are sorted, so the "less" bits form a prefix.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            less[i] = (CW'(i) < r_cnt) && ({r_size[i], r_id[i]} < {r_nsize, r_nid});
            eq[i]   = (CW'(i) < r_cnt) && ({r_size[i], r_id[i]} == KEY_W'({r_nsize, r_nid}));
        end
    end

    assign dup       = |eq;
    assign full      = (r_cnt >= CW'(CAPACITY));
    assign sum_lt    = (r_sum < SUMW'(r_req));
    assign small_ign = (r_cnt != '0) && (r_size[0] >= r_nsize);
    assign sum_less0 = r_sum - SUMW'(r_size[0]);
    assign drop_ok   = (r_cnt != '0) && (sum_less0 >= SUMW'(r_req));
    assign drain_last = ((r_k + CW'(1)) == r_cnt);
    assign out_free  = !o_out_valid || !i_out_stall;

    always_comb begin
        if (!sum_lt && small_ign) begin
            add_st = lics_pkg::ST_IGNORED;
        end else if (dup) begin
            add_st = lics_pkg::ST_IGNORED;
        end else if (full) begin
            add_st = lics_pkg::ST_FULL;
        end else begin
            add_st = lics_pkg::ST_INSERTED;
        end
    end
    assign add_ins = (add_st == lics_pkg::ST_INSERTED);

    assign o_sts.cmd        = r_cmd;
    assign o_sts.add_drop   = add_ins && !sum_lt;
    assign o_sts.cnt_zero   = (r_cnt == '0);
    assign o_sts.drop_ok    = drop_ok;
    assign o_sts.drain_last = drain_last;
    assign o_sts.out_free   = out_free;

    assign o_init_req = r_init;

    // Entry table: insert shifts the upper part up, drop and drain shift down.
    always_ff @(posedge i_clk) begin
        if (i_ctl.do_add && add_ins) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (!less[i]) begin
                    if (i == 0 || less[(i == 0) ? 0 : i - 1]) begin
                        r_size[i] <= r_nsize;
                        r_id[i]   <= r_nid;
                    end else begin
                        r_size[i] <= r_size[(i == 0) ? 0 : i - 1];
                        r_id[i]   <= r_id[(i == 0) ? 0 : i - 1];
                    end
                end
            end
        end else if (i_ctl.do_drop || i_ctl.put_entry) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                r_size[i] <= r_size[i + 1];
                r_id[i]   <= r_id[i + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd   <= i_cmd;
            r_nid   <= i_item_id;
            r_nsize <= i_item_size;
            r_dec   <= i_decrease_amount;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_sum  <= '0;
            r_req  <= '0;
            r_init <= '0;
            r_k    <= '0;
            r_st   <= lics_pkg::ST_INSERTED;
        end else begin
            if (i_cfg_we) begin
                r_init <= i_cfg_data;
                r_req  <= i_cfg_data;
            end
            if (i_ctl.do_add) begin
                r_st <= add_st;
                if (add_ins) begin
                    r_cnt <= r_cnt + CW'(1);
                    r_sum <= r_sum + SUMW'(r_nsize);
                end
            end
            if (i_ctl.do_lower) begin
                r_st  <= lics_pkg::ST_LOWERED;
                r_req <= (r_dec < r_req) ? (r_req - r_dec) : '0;
            end
            if (i_ctl.drain_start) begin
                r_st  <= lics_pkg::ST_EMPTY;
                r_req <= r_init;
                r_k   <= '0;
            end
            if (i_ctl.do_drop) begin
                r_cnt <= r_cnt - CW'(1);
                r_sum <= sum_less0;
            end
            if (i_ctl.put_entry) begin
                r_k <= r_k + CW'(1);
                if (drain_last) begin
                    r_cnt <= '0;
                    r_sum <= '0;
                end
            end
        end
    end

    // Output register; a waiting result blocks the next result load and drain shift, but not add, lower or drop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_ctl.put_result || i_ctl.put_entry) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.put_result) begin
            o_status          <= r_st;
            o_entry_id        <= '0;
            o_entry_size      <= '0;
            o_held_count      <= lics_pkg::HCOUNT_W'(r_cnt);
            o_held_sum        <= lics_pkg::HSUM_W'(r_sum);
            o_requirement_now <= r_req;
            o_last            <= 1'b1;
        end else if (i_ctl.put_entry) begin
            o_status          <= lics_pkg::ST_ENTRY;
            o_entry_id        <= r_id[0];
            o_entry_size      <= r_size[0];
            o_held_count      <= lics_pkg::HCOUNT_W'(r_cnt);
            o_held_sum        <= lics_pkg::HSUM_W'(r_sum);
            o_requirement_now <= r_req;
            o_last            <= drain_last;
        end
    end

endmodule
`default_nettype wire

### rtl/core/largest_items_covering_sum.sv
// Keeps the fewest largest items whose sizes add up to a required amount.
// Input channel: i_in_valid / o_in_stall with cmd, item id, item size and
// decrease amount. A transfer happens on a rising edge with valid high and
// stall low. Output channel: o_out_valid / i_out_stall with one result per
// add or lower, and one result per held entry (smallest first) for a drain,
// o_last marking the final result of a command.
// The block handles one command at a time. A transfer is captured in IDLE
// and applied in EXEC. An add that needs no drop pass goes straight to RES,
// which loads its result when the output is free; a lower, or an add
// inserted while the requirement is already met, first passes through DROP,
// which removes entries one per cycle from the small end of the table. A
// nonempty drain loads the held entries in turn from DRAIN, each when the
// output is free; an empty drain goes to RES. The next transfer can be taken
// in the cycle after the final result is loaded. The table is a row of sorted
// cells that all compare with a new item at once, so an insert is done in EXEC.
// The APB port at byte address 0 holds the 48-bit initial requirement;
// a write also loads the running requirement. Write only while idle.
// Synchronous reset empties the table and clears both requirements.
// When the receiver stalls, the result stays in the output register and
// the block waits before producing the next one.
`default_nettype none
module largest_items_covering_sum #(
    parameter int unsigned CAPACITY  = lics_pkg::CAPACITY,
    parameter int unsigned SIZE_BITS = lics_pkg::SIZE_BITS,
    parameter int unsigned ID_BITS   = lics_pkg::ID_BITS
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire [lics_pkg::CMD_W-1:0]       i_cmd,
    input  wire [ID_BITS-1:0]               i_item_id,
    input  wire [SIZE_BITS-1:0]             i_item_size,
    input  wire [SIZE_BITS-1:0]             i_decrease_amount,
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output logic [lics_pkg::STATUS_W-1:0]   o_status,
    output logic [ID_BITS-1:0]              o_entry_id,
    output logic [SIZE_BITS-1:0]            o_entry_size,
    output logic [lics_pkg::HCOUNT_W-1:0]   o_held_count,
    output logic [lics_pkg::HSUM_W-1:0]     o_held_sum,
    output logic [SIZE_BITS-1:0]            o_requirement_now,
    output logic                            o_last,
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire [lics_pkg::PADDR_W-1:0]     paddr,
    input  wire [lics_pkg::PDATA_W-1:0]     pwdata,
    output logic [lics_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    lics_pkg::t_ctl       ctl;
    lics_pkg::t_sts       sts;
    logic                 idle;
    logic                 cfg_we;
    logic [SIZE_BITS-1:0] init_req;

    assign pready     = 1'b1;
    assign cfg_we     = psel && penable && pwrite && (paddr[3] == 1'b0);
    assign prdata     = (paddr[3] == 1'b0) ? lics_pkg::PDATA_W'(init_req) : '0;
    assign o_in_stall = !idle;

    lics_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_ctl      (ctl),
        .o_idle     (idle)
    );

    lics_dp #(
        .CAPACITY  (CAPACITY),
        .SIZE_BITS (SIZE_BITS),
        .ID_BITS   (ID_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (ctl),
        .o_sts             (sts),
        .i_cmd             (i_cmd),
        .i_item_id         (i_item_id),
        .i_item_size       (i_item_size),
        .i_decrease_amount (i_decrease_amount),
        .i_cfg_we          (cfg_we),
        .i_cfg_data        (pwdata[SIZE_BITS-1:0]),
        .o_init_req        (init_req),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_status          (o_status),
        .o_entry_id        (o_entry_id),
        .o_entry_size      (o_entry_size),
        .o_held_count      (o_held_count),
        .o_held_sum        (o_held_sum),
        .o_requirement_now (o_requirement_now),
        .o_last            (o_last)
    );

endmodule
`default_nettype wire

### rtl/core/lics_checker.sv
`default_nettype none
module lics_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            i_in_valid,
    input wire                            o_in_stall,
    input wire                            o_out_valid,
    input wire                            i_out_stall,
    input wire [lics_pkg::STATUS_W-1:0]   o_status,
    input wire [lics_pkg::HCOUNT_W-1:0]   o_held_count,
    input wire                            o_last
);

    // A held result stays presented until the receiver takes it.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // One command at a time: after a transfer the input side stalls.
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while busy");

    // An empty drain reports an empty table as its only result.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == lics_pkg::ST_EMPTY) |-> (o_held_count == '0) && o_last)
        else $error("empty drain result malformed");

    // Results other than drained entries always close their command.
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != lics_pkg::ST_ENTRY) |-> o_last)
        else $error("single result without last");

endmodule

bind largest_items_covering_sum lics_checker u_lics_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_status     (o_status),
    .o_held_count (o_held_count),
    .o_last       (o_last)
);
`default_nettype wire

### dv/tb_largest_items_covering_sum.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_largest_items_covering_sum;

    localparam int SB   = lics_pkg::SIZE_BITS;
    localparam int IB   = lics_pkg::ID_BITS;
    localparam int STW  = lics_pkg::STATUS_W;
    localparam int CNTW = lics_pkg::HCOUNT_W;
    localparam int HSW  = lics_pkg::HSUM_W;
    localparam int CMDW = lics_pkg::CMD_W;
    localparam int PAW  = lics_pkg::PADDR_W;
    localparam int PDW  = lics_pkg::PDATA_W;
    localparam int CAP  = lics_pkg::CAPACITY;
    localparam int WATCHDOG_LIMIT = 20000;

    // Command code with no meaning; the block takes it and gives no result.
    localparam logic [CMDW-1:0] CMD_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [CMDW-1:0] cmd;
        logic [IB-1:0]   id;
        logic [SB-1:0]   size;
        logic [SB-1:0]   dec;
    } t_cmd_item;

    typedef struct packed {
        logic [STW-1:0]  status;
        logic [IB-1:0]   id;
        logic [SB-1:0]   size;
        logic [CNTW-1:0] cnt;
        logic [HSW-1:0]  sum;
        logic [SB-1:0]   req;
        logic            last;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [CMDW-1:0] i_cmd = '0;
    logic [IB-1:0] i_item_id = '0;
    logic [SB-1:0] i_item_size = '0;
    logic [SB-1:0] i_decrease_amount = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [STW-1:0] o_status;
    logic [IB-1:0] o_entry_id;
    logic [SB-1:0] o_entry_size;
    logic [CNTW-1:0] o_held_count;
    logic [HSW-1:0] o_held_sum;
    logic [SB-1:0] o_requirement_now;
    logic o_last;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PAW-1:0] paddr = '0;
    logic [PDW-1:0] pwdata = '0;
    logic [PDW-1:0] prdata;
    logic pready;

    largest_items_covering_sum u_top (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Predictor state: sorted table of held items.
    logic [SB-1:0]  tbl_size [CAP];
    logic [IB-1:0]  tbl_id [CAP];
    int             tbl_cnt;
    logic [HSW-1:0] tbl_sum;
    logic [SB-1:0]  req_run, req_init;

    t_cmd_item pending_items[$];
    t_result   expected_results[$];
    int mismatches = 0, transfers_in = 0, results_seen = 0, drains_seen = 0;
    int idle_cycles = 0;
    bit quiet_in = 1'b0, quiet_out = 1'b0, hold_sender = 1'b0;

    function automatic void shift_out_smallest();
        for (int i = 0; i < tbl_cnt - 1; i++) begin
            tbl_size[i] = tbl_size[i+1];
            tbl_id[i] = tbl_id[i+1];
        end
        tbl_cnt--;
    endfunction

    function automatic void trim_surplus();
        while (tbl_cnt > 0 && tbl_sum - HSW'(tbl_size[0]) >= HSW'(req_run)) begin
            tbl_sum -= HSW'(tbl_size[0]);
            shift_out_smallest();
        end
    endfunction

    function automatic logic [STW-1:0] place_item(logic [SB-1:0] sz, logic [IB-1:0] id);
        int p;
        p = 0;
        while (p < tbl_cnt && (tbl_size[p] < sz || (tbl_size[p] == sz && tbl_id[p] < id)))
            p++;
        if (p < tbl_cnt && tbl_size[p] == sz && tbl_id[p] == id) return lics_pkg::ST_IGNORED;
        if (tbl_cnt >= CAP) return lics_pkg::ST_FULL;
        for (int i = tbl_cnt; i > p; i--) begin
            tbl_size[i] = tbl_size[i-1];
            tbl_id[i] = tbl_id[i-1];
        end
        tbl_size[p] = sz;
        tbl_id[p] = id;
        tbl_cnt++;
        tbl_sum += HSW'(sz);
        return lics_pkg::ST_INSERTED;
    endfunction

    function automatic void predict_results(t_cmd_item it);
        t_result r;
        r = '0;
        r.last = 1'b1;
        case (it.cmd)
            lics_pkg::CMD_ADD: begin
                if (HSW'(req_run) > tbl_sum) begin
                    r.status = place_item(it.size, it.id);
                end else if (tbl_cnt > 0 && tbl_size[0] >= it.size) begin
                    r.status = lics_pkg::ST_IGNORED;
                end else begin
                    r.status = place_item(it.size, it.id);
                    if (r.status == lics_pkg::ST_INSERTED) trim_surplus();
                end
                r.cnt = CNTW'(tbl_cnt); r.sum = tbl_sum; r.req = req_run;
                expected_results = {expected_results, r};
            end
            lics_pkg::CMD_LOWER: begin
                req_run -= (it.dec < req_run) ? it.dec : req_run;
                trim_surplus();
                r.status = lics_pkg::ST_LOWERED;
                r.cnt = CNTW'(tbl_cnt); r.sum = tbl_sum; r.req = req_run;
                expected_results = {expected_results, r};
            end
            lics_pkg::CMD_DRAIN: begin
                req_run = req_init;
                if (tbl_cnt == 0) begin
                    r.status = lics_pkg::ST_EMPTY; r.sum = tbl_sum; r.req = req_run;
                    expected_results = {expected_results, r};
                end else begin
                    for (int i = 0; i < tbl_cnt; i++) begin
                        r.status = lics_pkg::ST_ENTRY; r.id = tbl_id[i]; r.size = tbl_size[i];
                        r.cnt = CNTW'(tbl_cnt); r.sum = tbl_sum; r.req = req_run;
                        r.last = (i == tbl_cnt - 1);
                        expected_results = {expected_results, r};
                    end
                end
                tbl_cnt = 0;
                tbl_sum = '0;
            end
            default: ;
        endcase
    endfunction

    // Driver.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || !o_in_stall) begin
                if (i_in_valid) begin
                    transfers_in++;
                    predict_results(pending_items.pop_front());
                end
                if (pending_items.size() > 0 && !hold_sender &&
                    (quiet_in || $urandom_range(99) >= 15)) begin
                    i_in_valid <= 1'b1;
                    i_cmd <= pending_items[0].cmd;
                    i_item_id <= pending_items[0].id;
                    i_item_size <= pending_items[0].size;
                    i_decrease_amount <= pending_items[0].dec;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= quiet_out ? 1'b0 : ($urandom_range(99) < 15);
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_status, o_entry_id, o_entry_size, o_held_count, o_held_sum,
                    o_requirement_now, o_last};
            results_seen++;
            if (got.status == lics_pkg::ST_ENTRY && got.last) drains_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %p", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic queue_item(logic [CMDW-1:0] c, logic [IB-1:0] id, logic [SB-1:0] sz,
                              logic [SB-1:0] d);
        t_cmd_item it;
        it.cmd = c; it.id = id; it.size = sz; it.dec = d;
        pending_items = {pending_items, it};
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_requirement(logic [SB-1:0] v);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= PDW'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        req_init = v;
        req_run = v;
    endtask

    function automatic logic [SB-1:0] rand_size(int mode);
        case (mode)
            0: return SB'($urandom_range(1000));
            1: return SB'({$urandom, $urandom});
            default: return ($urandom_range(3) == 0) ? {SB{1'b1}} : SB'($urandom_range(2));
        endcase
    endfunction

    task automatic queue_random_phase(int n, int mode);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 70)
                queue_item(lics_pkg::CMD_ADD, IB'($urandom_range(mode == 2 ? 3 : 65535)),
                           rand_size(mode), SB'($urandom));
            else if (r < 85)
                queue_item(lics_pkg::CMD_LOWER, IB'($urandom), SB'($urandom),
                           (r < 78) ? rand_size(mode) : {SB{1'b1}});
            else if (r < 95)
                queue_item(lics_pkg::CMD_DRAIN, IB'($urandom), rand_size(1), rand_size(1));
            else
                queue_item(CMD_UNKNOWN, IB'($urandom), rand_size(1), rand_size(1));
        end
        queue_item(lics_pkg::CMD_DRAIN, '0, '0, '0);
    endtask

    initial begin
        tbl_cnt = 0; tbl_sum = '0; req_run = '0; req_init = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero requirement: every insert is dropped straight away.
        queue_item(lics_pkg::CMD_ADD, 16'h0001, 48'd5, '0);
        queue_item(lics_pkg::CMD_DRAIN, '0, '0, '0);
        queue_item(CMD_UNKNOWN, '1, '1, '1);
        wait_drained();

        write_requirement(48'd100);
        queue_item(lics_pkg::CMD_ADD, 16'h0000, 48'd0, '0);
        queue_item(lics_pkg::CMD_ADD, 16'hFFFF, 48'd60, '0);
        queue_item(lics_pkg::CMD_ADD, 16'hFFFF, 48'd60, '0);   // duplicate key
        queue_item(lics_pkg::CMD_ADD, 16'h0002, 48'd60, '0);
        queue_item(lics_pkg::CMD_ADD, 16'h0003, 48'd10, '0);   // larger than smallest
        queue_item(lics_pkg::CMD_ADD, 16'h0004, 48'hFFFF_FFFF_FFFF, '0);
        queue_item(lics_pkg::CMD_LOWER, '0, '0, 48'd30);
        queue_item(lics_pkg::CMD_LOWER, '0, '0, 48'hFFFF_FFFF_FFFF);
        queue_item(lics_pkg::CMD_DRAIN, '0, '0, '0);
        queue_item(lics_pkg::CMD_DRAIN, '0, '0, '0);
        wait_drained();

        // Fill the table to capacity and beyond.
        write_requirement({SB{1'b1}});
        for (int i = 0; i < CAP + 3; i++)
            queue_item(lics_pkg::CMD_ADD, IB'(i), SB'(i + 1), '0);
        queue_item(lics_pkg::CMD_DRAIN, '0, '0, '0);
        wait_drained();

        write_requirement(48'd2000);
        queue_random_phase(80, 0);
        wait_drained();
        write_requirement({SB{1'b1}} >> 8);
        quiet_in = 1'b1; quiet_out = 1'b1;
        queue_random_phase(80, 1);
        wait_drained();
        quiet_in = 1'b0; quiet_out = 1'b0;
        write_requirement(48'd3);
        queue_random_phase(70, 2);
        hold_sender = 1'b0;
        while (pending_items.size() > 40) @(posedge i_clk);
        hold_sender = 1'b1;
        while (expected_results.size() > 0 || i_in_valid) @(posedge i_clk);
        hold_sender = 1'b0;
        wait_drained();
        write_requirement({SB{1'b1}});
        queue_random_phase(47, 0);
        wait_drained();

        $display("Covered %0d input transfers and %0d results, %0d nonempty drains.",
                 transfers_in, results_seen, drains_seen);
        $display("Requirement settings from zero to the full 48-bit range were used.");
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
rtl/core/lics_pkg.sv
rtl/core/lics_ctrl.sv
rtl/core/lics_dp.sv
rtl/core/largest_items_covering_sum.sv
rtl/core/lics_checker.sv
dv/tb_largest_items_covering_sum.sv
